FILE: hdl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every rising edge outside reset
`define FSWQ_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("fswq assertion failed");

// expression that must never be true outside reset
`define FSWQ_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("fswq forbidden condition seen");

`endif

FILE: hdl/fswq_pkg.sv
// ----------------------------------------------------------------------------
// fswq_pkg
// Shared types and codes of the sector write-back queue.
// ----------------------------------------------------------------------------
`default_nettype none

package fswq_pkg;

  // slot storage
  localparam int NumSlots   = 8;
  localparam int SlotW      = $clog2(NumSlots);
  localparam int CountW     = SlotW + 1;
  localparam int AddrW      = 32;
  localparam int WordW      = 32;
  localparam int SlotEntryW = AddrW + 1;
  localparam logic [WordW-1:0] ErasedWord = '1;

  // input kinds
  typedef enum logic [1:0] {
    KindCmd    = 2'd0,
    KindDone   = 2'd1,
    KindPair   = 2'd2,
    KindUnused = 2'd3
  } kind_e;

  // host command codes
  localparam logic [7:0] CmdInit    = 8'd1;
  localparam logic [7:0] CmdWrite   = 8'd2;
  localparam logic [7:0] CmdCompare = 8'd3;

  // result status
  typedef enum logic [1:0] {
    StatOk      = 2'd0,
    StatBusy    = 2'd1,
    StatBad     = 2'd2,
    StatNothing = 2'd3
  } status_e;

  // flash operations
  typedef enum logic [2:0] {
    OpNone  = 3'd0,
    OpInit  = 3'd1,
    OpRead  = 3'd2,
    OpErase = 3'd3,
    OpWrite = 3'd4
  } flash_op_e;

endpackage

`default_nettype wire

FILE: hdl/fswq_ram.sv
// ----------------------------------------------------------------------------
// fswq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fswq_ram #(
  parameter int Width = 8,
  parameter int Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: hdl/flash_sector_writeback_queue.sv
// ----------------------------------------------------------------------------
// flash_sector_writeback_queue
// Queues sector write jobs in slots and sequences read, erase and write.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive kind/command/slot/address/word fields with start
//   high; the transfer happens on an edge where start is high and busy low.
//   Busy rises in the following cycle and stays high until the result is out.
//   Result channel: done_o is high for exactly one cycle with the result
//   fields; there is no back-pressure, the receiver must take it then.
//   Host commands, word pairs and stray events pass only the execute state
//   before the result; a taken flash-done event adds the slot and decide
//   states and, if it starts the next job, ring, slot and decide again
//   (two passes through the ring and slot memories, one registered read
//   each). free_mask_o and running_o show the state after the step while
//   done_o is high. slots_in_use is written through cfg_we_i/cfg_wdata_i;
//   the user must write it only while idle; no check in the block enforces
//   this. Reset empties the queue, frees all slots and sets slots_in_use
//   to 7; the slot and ring memories need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module flash_sector_writeback_queue (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    kind_i,
  input  logic [7:0]                    command_code_i,
  input  logic [fswq_pkg::SlotW-1:0]    slot_index_i,
  input  logic [fswq_pkg::AddrW-1:0]    flash_address_i,
  input  logic                          spi_busy_i,
  input  logic [fswq_pkg::WordW-1:0]    read_word_i,
  input  logic [fswq_pkg::WordW-1:0]    source_word_i,
  input  logic                          cfg_we_i,
  input  logic [fswq_pkg::CountW-1:0]   cfg_wdata_i,
  output logic                          done_o,
  output logic [1:0]                    status_o,
  output logic [2:0]                    flash_op_o,
  output logic [fswq_pkg::AddrW-1:0]    op_address_o,
  output logic [fswq_pkg::SlotW-1:0]    op_slot_o,
  output logic [fswq_pkg::NumSlots-1:0] free_mask_o,
  output logic                          running_o
);

  import fswq_pkg::*;

  typedef enum logic [2:0] {
    StIdle, StExec, StRing, StSlot, StDecide, StOut
  } state_e;

  typedef enum logic [1:0] {
    PhIdle  = 2'd0,
    PhRead  = 2'd1,
    PhErase = 2'd2,
    PhWrite = 2'd3
  } phase_e;

  state_e              state_q, state_d;
  phase_e              phase_q, phase_d;
  logic [1:0]          kind_q, kind_d;
  logic [7:0]          code_q, code_d;
  logic [SlotW-1:0]    sidx_q, sidx_d;
  logic [AddrW-1:0]    addr_q, addr_d;
  logic                spi_q, spi_d;
  logic [WordW-1:0]    rd_q, rd_d;
  logic [WordW-1:0]    src_q, src_d;
  logic [CountW-1:0]   slots_q, slots_d;
  logic [NumSlots-1:0] slot_busy_q, slot_busy_d;
  logic [SlotW-1:0]    head_q, head_d;
  logic [SlotW-1:0]    tail_q, tail_d;
  logic [CountW-1:0]   count_q, count_d;
  logic                erased_q, erased_d;
  logic                match_q, match_d;
  logic [SlotW-1:0]    slot_q, slot_d;
  logic                start_mode_q, start_mode_d;
  status_e             status_q, status_d;
  flash_op_e           op_q, op_d;
  logic [AddrW-1:0]    op_addr_q, op_addr_d;
  logic [SlotW-1:0]    op_slot_q, op_slot_d;

  logic                  ring_we;
  logic [SlotW-1:0]      ring_rdata;
  logic                  slot_we;
  logic [SlotEntryW-1:0] slot_wdata;
  logic [SlotEntryW-1:0] slot_rdata;
  logic                  entry_compare;
  logic [AddrW-1:0]      entry_addr;
  logic                  finish_now;

  // order ring: slot numbers in arrival order, read at the head
  fswq_ram #(
    .Width (SlotW),
    .Depth (NumSlots)
  ) u_ring_ram (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (tail_q),
    .wdata_i (sidx_q),
    .raddr_i (head_q),
    .rdata_o (ring_rdata)
  );

  // slot table: compare flag and sector address, read at the head slot
  fswq_ram #(
    .Width (SlotEntryW),
    .Depth (NumSlots)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (sidx_q),
    .wdata_i (slot_wdata),
    .raddr_i (ring_rdata),
    .rdata_o (slot_rdata)
  );

  assign slot_wdata    = {(code_q == CmdCompare), addr_q};
  assign entry_compare = slot_rdata[SlotEntryW-1];
  assign entry_addr    = slot_rdata[AddrW-1:0];

  // next-state logic
  always_comb begin
    state_d      = state_q;
    phase_d      = phase_q;
    kind_d       = kind_q;
    code_d       = code_q;
    sidx_d       = sidx_q;
    addr_d       = addr_q;
    spi_d        = spi_q;
    rd_d         = rd_q;
    src_d        = src_q;
    slots_d      = slots_q;
    slot_busy_d  = slot_busy_q;
    head_d       = head_q;
    tail_d       = tail_q;
    count_d      = count_q;
    erased_d     = erased_q;
    match_d      = match_q;
    slot_d       = slot_q;
    start_mode_d = start_mode_q;
    status_d     = status_q;
    op_d         = op_q;
    op_addr_d    = op_addr_q;
    op_slot_d    = op_slot_q;
    ring_we      = 1'b0;
    slot_we      = 1'b0;
    finish_now   = 1'b0;

    // configuration register
    if (cfg_we_i) begin
      slots_d = cfg_wdata_i;
    end

    unique case (state_q)
      StIdle: begin
        if (start) begin
          kind_d  = kind_i;
          code_d  = command_code_i;
          sidx_d  = slot_index_i;
          addr_d  = flash_address_i;
          spi_d   = spi_busy_i;
          rd_d    = read_word_i;
          src_d   = source_word_i;
          state_d = StExec;
        end
      end

      StExec: begin
        status_d  = StatNothing;
        op_d      = OpNone;
        op_addr_d = '0;
        op_slot_d = '0;
        state_d   = StOut;
        unique case (kind_e'(kind_q))
          KindCmd: begin
            if (spi_q) begin
              status_d = StatBusy;
            end else if (code_q == CmdInit) begin
              if (count_q != '0) begin
                status_d = StatBad;
              end else begin
                status_d = StatOk;
                op_d     = OpInit;
              end
            end else if (code_q == CmdWrite || code_q == CmdCompare) begin
              if ({1'b0, sidx_q} >= slots_q || slot_busy_q[sidx_q]) begin
                status_d = StatBad;
              end else begin
                // enqueue the job
                slot_busy_d[sidx_q] = 1'b1;
                slot_we             = 1'b1;
                ring_we             = 1'b1;
                tail_d              = tail_q + SlotW'(1);
                count_d             = count_q + CountW'(1);
                status_d            = StatOk;
                // empty queue: the new job starts at once
                if (count_q == '0) begin
                  op_slot_d = sidx_q;
                  op_addr_d = addr_q;
                  if (code_q == CmdCompare) begin
                    erased_d = 1'b1;
                    match_d  = 1'b1;
                    phase_d  = PhRead;
                    op_d     = OpRead;
                  end else begin
                    phase_d = PhWrite;
                    op_d    = OpWrite;
                  end
                end
              end
            end else begin
              status_d = StatBad;
            end
          end
          KindDone: begin
            if (phase_q != PhIdle && count_q != '0) begin
              status_d     = StatOk;
              start_mode_d = 1'b0;
              state_d      = StSlot;
            end
          end
          KindPair: begin
            if (phase_q == PhRead) begin
              if (rd_q != ErasedWord) begin
                erased_d = 1'b0;
              end
              if (rd_q != src_q) begin
                match_d = 1'b0;
              end
              status_d = StatOk;
            end
          end
          default: begin
          end
        endcase
      end

      // wait for the ring read at the new head
      StRing: begin
        state_d = StSlot;
      end

      // head slot number is out, slot table read is on its way
      StSlot: begin
        slot_d  = ring_rdata;
        state_d = StDecide;
      end

      StDecide: begin
        state_d = StOut;
        if (start_mode_q) begin
          // start the next queued job
          op_slot_d = slot_q;
          op_addr_d = entry_addr;
          if (entry_compare) begin
            erased_d = 1'b1;
            match_d  = 1'b1;
            phase_d  = PhRead;
            op_d     = OpRead;
          end else begin
            phase_d = PhWrite;
            op_d    = OpWrite;
          end
        end else begin
          unique case (phase_q)
            PhRead: begin
              if (match_q) begin
                finish_now = 1'b1;
              end else begin
                phase_d   = erased_q ? PhWrite : PhErase;
                op_d      = erased_q ? OpWrite : OpErase;
                op_slot_d = slot_q;
                op_addr_d = entry_addr;
              end
            end
            PhErase: begin
              phase_d   = PhWrite;
              op_d      = OpWrite;
              op_slot_d = slot_q;
              op_addr_d = entry_addr;
            end
            default: begin
              finish_now = 1'b1;
            end
          endcase
          // retire the head job, then start the next one if any
          if (finish_now) begin
            slot_busy_d[slot_q] = 1'b0;
            head_d              = head_q + SlotW'(1);
            count_d             = count_q - CountW'(1);
            if (count_q == CountW'(1)) begin
              phase_d = PhIdle;
            end else begin
              start_mode_d = 1'b1;
              state_d      = StRing;
            end
          end
        end
      end

      StOut: begin
        state_d = StIdle;
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      phase_q      <= PhIdle;
      kind_q       <= '0;
      code_q       <= '0;
      sidx_q       <= '0;
      addr_q       <= '0;
      spi_q        <= 1'b0;
      rd_q         <= '0;
      src_q        <= '0;
      slots_q      <= CountW'(7);
      slot_busy_q  <= '0;
      head_q       <= '0;
      tail_q       <= '0;
      count_q      <= '0;
      erased_q     <= 1'b1;
      match_q      <= 1'b1;
      slot_q       <= '0;
      start_mode_q <= 1'b0;
      status_q     <= StatNothing;
      op_q         <= OpNone;
      op_addr_q    <= '0;
      op_slot_q    <= '0;
    end else begin
      state_q      <= state_d;
      phase_q      <= phase_d;
      kind_q       <= kind_d;
      code_q       <= code_d;
      sidx_q       <= sidx_d;
      addr_q       <= addr_d;
      spi_q        <= spi_d;
      rd_q         <= rd_d;
      src_q        <= src_d;
      slots_q      <= slots_d;
      slot_busy_q  <= slot_busy_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      count_q      <= count_d;
      erased_q     <= erased_d;
      match_q      <= match_d;
      slot_q       <= slot_d;
      start_mode_q <= start_mode_d;
      status_q     <= status_d;
      op_q         <= op_d;
      op_addr_q    <= op_addr_d;
      op_slot_q    <= op_slot_d;
    end
  end

  // free slots within the usable range
  always_comb begin
    for (int n = 0; n < NumSlots; n++) begin
      free_mask_o[n] = (slots_q > CountW'(n)) && !slot_busy_q[n];
    end
  end

  assign busy         = (state_q != StIdle);
  assign done_o       = (state_q == StOut);
  assign status_o     = status_q;
  assign flash_op_o   = op_q;
  assign op_address_o = op_addr_q;
  assign op_slot_o    = op_slot_q;
  assign running_o    = (count_q != '0);

endmodule

`default_nettype wire

FILE: hdl/fswq_checker.sv
// ----------------------------------------------------------------------------
// fswq_checker
// Port-level checks of the sector write-back queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module fswq_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  input  logic                          busy,
  input  logic                          done_o,
  input  logic [1:0]                    status_o,
  input  logic [2:0]                    flash_op_o,
  input  logic [fswq_pkg::AddrW-1:0]    op_address_o,
  input  logic [fswq_pkg::SlotW-1:0]    op_slot_o
);

  import fswq_pkg::*;

  // an accepted transfer makes the block busy
  `FSWQ_ASSERT(a_accept_busy, clk_i, rst_ni, (start && !busy) |=> busy)

  // a result only appears while an item is in flight
  `FSWQ_ASSERT(a_done_busy, clk_i, rst_ni, done_o |-> busy)

  // one result per item, never two strobes in a row
  `FSWQ_ASSERT(a_single_done, clk_i, rst_ni, done_o |=> !done_o)

  // refused or idle steps never start a flash operation
  `FSWQ_NEVER(a_refused_no_op, clk_i, rst_ni,
    done_o && (status_o != StatOk) && (flash_op_o != OpNone))

  // no operation means zero address and slot
  `FSWQ_NEVER(a_none_zero, clk_i, rst_ni,
    done_o && (flash_op_o == OpNone) && ((op_address_o != '0) || (op_slot_o != '0)))

endmodule

bind flash_sector_writeback_queue fswq_checker u_fswq_checker (.*);

`default_nettype wire

FILE: test/flash_sector_writeback_queue_tb.sv
// ----------------------------------------------------------------------------
// flash_sector_writeback_queue_tb
// Acts as host and as flash controller for the sector write-back queue: a
// directed run through the refusals and the read, erase and write paths, then
// random command, done and word-pair traffic over several slot counts. Every
// result is checked against a behavioural model of the queue kept alongside.
// ----------------------------------------------------------------------------
module flash_sector_writeback_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fswq_pkg::*;

  localparam int unsigned StallLimit = 1000;
  localparam int unsigned RandomItems = 1350;

  // one input item and one result, at the widths of the ports
  typedef struct packed {
    kind_e        kind;
    logic [7:0]   code;
    logic [2:0]   slot;
    logic [31:0]  addr;
    logic         spi_busy;
    logic [31:0]  rd_word;
    logic [31:0]  src_word;
  } sector_req_t;

  typedef struct packed {
    status_e      status;
    flash_op_e    op;
    logic [31:0]  addr;
    logic [2:0]   slot;
    logic [7:0]   free_mask;
    logic         running;
  } sector_resp_t;

  typedef enum logic [1:0] {PhIdle, PhRead, PhErase, PhWrite} job_phase_e;

  // model of the slot queue and the list of results still to come
  class queue_tracker;
    logic [3:0]   slot_limit;
    bit           slot_taken[8];
    bit           slot_compares[8];
    logic [31:0]  slot_sector[8];
    logic [2:0]   job_order[8];
    logic [2:0]   order_head;
    logic [2:0]   order_tail;
    int unsigned  jobs_queued;
    job_phase_e   job_phase;
    bit           read_erased;
    bit           read_matches;
    sector_resp_t awaited[$];
    int unsigned  error_count;

    function new();
      slot_limit = 4'd7;
      foreach (slot_taken[i]) begin
        slot_taken[i] = 1'b0;
        slot_compares[i] = 1'b0;
        slot_sector[i] = '0;
        job_order[i] = '0;
      end
      order_head = '0;
      order_tail = '0;
      jobs_queued = 0;
      job_phase = PhIdle;
      read_erased = 1'b1;
      read_matches = 1'b1;
      error_count = 0;
    endfunction

    function int unsigned usable();
      return (slot_limit > NumSlots) ? NumSlots : slot_limit;
    endfunction

    // start the job at the head of the queue
    function flash_op_e launch_head(output logic [2:0] s);
      s = job_order[order_head];
      if (slot_compares[s]) begin
        read_erased = 1'b1;
        read_matches = 1'b1;
        job_phase = PhRead;
        return OpRead;
      end
      job_phase = PhWrite;
      return OpWrite;
    endfunction

    // free the head slot and move on to the next job, if one waits
    function flash_op_e retire_head(output logic [2:0] s);
      s = '0;
      slot_taken[job_order[order_head]] = 1'b0;
      order_head = order_head + 3'd1;
      if (jobs_queued > 0) jobs_queued--;
      if (jobs_queued == 0) begin
        job_phase = PhIdle;
        return OpNone;
      end
      return launch_head(s);
    endfunction

    // step the model for one accepted item and queue its result
    function status_e take_request(sector_req_t r);
      sector_resp_t want;
      status_e      st;
      flash_op_e    op;
      logic [2:0]   s;
      logic [2:0]   head_slot;
      bit           sector_op;
      st = StatNothing;
      op = OpNone;
      s = '0;
      head_slot = job_order[order_head];
      case (r.kind)
        KindCmd: begin
          if (r.spi_busy) begin
            st = StatBusy;
          end else if (r.code == CmdInit) begin
            if (jobs_queued != 0) begin
              st = StatBad;
            end else begin
              st = StatOk;
              op = OpInit;
            end
          end else if (r.code == CmdWrite || r.code == CmdCompare) begin
            if (r.slot >= usable() || slot_taken[r.slot]) begin
              st = StatBad;
            end else begin
              slot_taken[r.slot] = 1'b1;
              slot_compares[r.slot] = (r.code == CmdCompare);
              slot_sector[r.slot] = r.addr;
              job_order[order_tail] = r.slot;
              order_tail = order_tail + 3'd1;
              jobs_queued++;
              st = StatOk;
              if (jobs_queued == 1) op = launch_head(s);
            end
          end else begin
            st = StatBad;
          end
        end
        KindDone: begin
          if (job_phase != PhIdle && jobs_queued != 0) begin
            st = StatOk;
            case (job_phase)
              PhRead: begin
                if (read_matches) begin
                  op = retire_head(s);
                end else if (!read_erased) begin
                  job_phase = PhErase;
                  op = OpErase;
                  s = head_slot;
                end else begin
                  job_phase = PhWrite;
                  op = OpWrite;
                  s = head_slot;
                end
              end
              PhErase: begin
                job_phase = PhWrite;
                op = OpWrite;
                s = head_slot;
              end
              default: op = retire_head(s);
            endcase
          end
        end
        KindPair: begin
          if (job_phase == PhRead) begin
            if (r.rd_word != ErasedWord) read_erased = 1'b0;
            if (r.rd_word != r.src_word) read_matches = 1'b0;
            st = StatOk;
          end
        end
        default: ;
      endcase
      sector_op = (op == OpRead || op == OpErase || op == OpWrite);
      want.status = st;
      want.op = op;
      want.addr = sector_op ? slot_sector[s] : '0;
      want.slot = sector_op ? s : '0;
      want.free_mask = '0;
      for (int i = 0; i < usable(); i++) begin
        if (!slot_taken[i]) want.free_mask[i] = 1'b1;
      end
      want.running = (jobs_queued != 0);
      awaited.push_back(want);
      return st;
    endfunction

    function string show(sector_resp_t r);
      return $sformatf("status=%0d op=%0d addr=%h slot=%0d free=%b run=%0d",
                       r.status, r.op, r.addr, r.slot, r.free_mask, r.running);
    endfunction

    function void note_error(string msg);
      error_count++;
      if (error_count <= 10) $display("mismatch: %s", msg);
    endfunction

    // compare one result with the oldest one outstanding
    function void check_response(sector_resp_t got);
      sector_resp_t want;
      if (awaited.size() == 0) begin
        note_error({"result with none outstanding: ", show(got)});
        return;
      end
      want = awaited.pop_front();
      if (got.status !== want.status || got.op !== want.op ||
          got.addr !== want.addr || got.slot !== want.slot ||
          got.free_mask !== want.free_mask || got.running !== want.running)
        note_error({"expected ", show(want), " got ", show(got)});
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [1:0]           kind_i = '0;
  logic [7:0]           command_code_i = '0;
  logic [SlotW-1:0]     slot_index_i = '0;
  logic [AddrW-1:0]     flash_address_i = '0;
  logic                 spi_busy_i = 1'b0;
  logic [WordW-1:0]     read_word_i = '0;
  logic [WordW-1:0]     source_word_i = '0;
  logic                 cfg_we_i = 1'b0;
  logic [CountW-1:0]    cfg_wdata_i = '0;
  logic                 done_o;
  logic [1:0]           status_o;
  logic [2:0]           flash_op_o;
  logic [AddrW-1:0]     op_address_o;
  logic [SlotW-1:0]     op_slot_o;
  logic [NumSlots-1:0]  free_mask_o;
  logic                 running_o;

  queue_tracker tracker = new();
  int unsigned  counted = 0;
  int unsigned  stall_cycles = 0;
  int unsigned  pair_style = 0;
  int           slot_plan[7] = '{8, 3, 1, 0, 15, 5, 7};

  flash_sector_writeback_queue u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .kind_i          (kind_i),
    .command_code_i  (command_code_i),
    .slot_index_i    (slot_index_i),
    .flash_address_i (flash_address_i),
    .spi_busy_i      (spi_busy_i),
    .read_word_i     (read_word_i),
    .source_word_i   (source_word_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .flash_op_o      (flash_op_o),
    .op_address_o    (op_address_o),
    .op_slot_o       (op_slot_o),
    .free_mask_o     (free_mask_o),
    .running_o       (running_o)
  );

  // clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && done_o)
      tracker.check_response('{status_e'(status_o), flash_op_e'(flash_op_o),
                               op_address_o, op_slot_o, free_mask_o, running_o});
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= StallLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic sector_req_t mk(kind_e k, logic [7:0] code, logic [2:0] slot,
                                     logic [31:0] addr, logic spi,
                                     logic [31:0] rd, logic [31:0] src);
    return '{k, code, slot, addr, spi, rd, src};
  endfunction

  // random item, steered by the job phase so that most jobs run to the end
  function automatic sector_req_t random_request();
    sector_req_t r;
    int unsigned pick;
    int unsigned free_list[$];
    r = '{KindCmd, 8'($urandom()), 3'($urandom()), $urandom(),
          ($urandom_range(0, 19) == 0), $urandom(), $urandom()};
    pick = $urandom_range(0, 99);
    case (tracker.job_phase)
      PhRead:  r.kind = (pick < 30) ? KindDone : (pick < 88) ? KindPair :
                        (pick < 98) ? KindCmd : KindUnused;
      PhIdle:  r.kind = (pick < 78) ? KindCmd : (pick < 88) ? KindDone :
                        (pick < 96) ? KindPair : KindUnused;
      default: r.kind = (pick < 45) ? KindDone : (pick < 88) ? KindCmd :
                        (pick < 96) ? KindPair : KindUnused;
    endcase
    case (r.kind)
      KindCmd: begin
        pick = $urandom_range(0, 99);
        if (pick < 5) r.code = CmdInit;
        else if (pick >= 10) r.code = $urandom_range(0, 1) ? CmdCompare : CmdWrite;
        for (int i = 0; i < tracker.usable(); i++)
          if (!tracker.slot_taken[i]) free_list.push_back(i);
        if (free_list.size() > 0 && $urandom_range(0, 4) != 0)
          r.slot = 3'(free_list[$urandom_range(0, free_list.size() - 1)]);
        if ($urandom_range(0, 2) == 0) r.addr[11:0] = '0;
        pair_style = $urandom_range(0, 3);
      end
      KindDone: pair_style = $urandom_range(0, 3);
      KindPair: begin
        // matching sector, erased sector, both, or anything
        case (pair_style)
          0: r.src_word = r.rd_word;
          1: r.rd_word = ErasedWord;
          2: begin
            r.rd_word = ErasedWord;
            r.src_word = ErasedWord;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int unsigned gap_cycles(bit idle_on);
    int unsigned p;
    if (!idle_on) return 0;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // present one item and hold it until the transfer
  task automatic issue(sector_req_t r);
    kind_i <= r.kind;
    command_code_i <= r.code;
    slot_index_i <= r.slot;
    flash_address_i <= r.addr;
    spi_busy_i <= r.spi_busy;
    read_word_i <= r.rd_word;
    source_word_i <= r.src_word;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    void'(tracker.take_request(r));
    counted++;
  endtask

  task automatic pause_sender(int unsigned cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // wait for all results, then write the slot count
  task automatic drain_and_configure(logic [3:0] value);
    start <= 1'b0;
    while (tracker.awaited.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    tracker.slot_limit = value;
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    logic [3:0]  limit_v;
    bit          idle_on;
    int unsigned quota_end;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // refusals, stray events and an init on an empty queue, slot count at reset
    issue(mk(KindDone, CmdWrite, 3'd0, '0, 1'b0, '0, '0));
    issue(mk(KindPair, 8'd0, 3'd0, '0, 1'b0, '1, '1));
    issue(mk(KindUnused, 8'($urandom()), 3'($urandom()), $urandom(), 1'b1,
             $urandom(), $urandom()));
    issue(mk(KindCmd, CmdWrite, 3'd0, '0, 1'b1, '0, '0));
    issue(mk(KindCmd, 8'd0, 3'd0, '0, 1'b0, '0, '0));
    issue(mk(KindCmd, 8'hFF, 3'd7, '1, 1'b0, '0, '0));
    issue(mk(KindCmd, CmdInit, 3'd0, '0, 1'b0, '0, '0));
    issue(mk(KindCmd, CmdWrite, 3'd7, 32'h0000_3000, 1'b0, '0, '0));
    // plain write, then init while running and a second job behind it
    issue(mk(KindCmd, CmdWrite, 3'd0, '1, 1'b0, '0, '0));
    issue(mk(KindCmd, CmdInit, 3'd0, '0, 1'b0, '0, '0));
    issue(mk(KindCmd, CmdCompare, 3'd1, 32'h0000_1000, 1'b0, '0, '0));
    issue(mk(KindCmd, CmdWrite, 3'd0, 32'h0000_5000, 1'b0, '0, '0));
    // matching sector finishes straight after the read
    issue(mk(KindDone, 8'd0, 3'd0, '0, 1'b0, '0, '0));
    issue(mk(KindPair, 8'd0, 3'd0, '0, 1'b0, 32'h1234_5678, 32'h1234_5678));
    issue(mk(KindPair, 8'd0, 3'd0, '0, 1'b0, '1, '1));
    issue(mk(KindCmd, CmdCompare, 3'd2, 32'h0000_2000, 1'b0, '0, '0));
    issue(mk(KindDone, 8'd0, 3'd0, '0, 1'b0, '0, '0));
    // dirty sector: erase then write
    issue(mk(KindPair, 8'd0, 3'd0, '0, 1'b0, 32'h0, 32'h1));
    issue(mk(KindCmd, CmdCompare, 3'd3, 32'hFFFF_F000, 1'b0, '0, '0));
    issue(mk(KindDone, 8'd0, 3'd0, '0, 1'b0, '0, '0));
    issue(mk(KindPair, 8'd0, 3'd0, '0, 1'b0, 32'h0, 32'h0));
    issue(mk(KindDone, 8'd0, 3'd0, '0, 1'b0, '0, '0));
    issue(mk(KindDone, 8'd0, 3'd0, '0, 1'b0, '0, '0));
    // erased sector with other data goes straight to write
    issue(mk(KindPair, 8'd0, 3'd0, '0, 1'b0, '1, 32'h0));
    issue(mk(KindDone, 8'd0, 3'd0, '0, 1'b0, '0, '0));
    issue(mk(KindDone, 8'd0, 3'd0, '0, 1'b0, '0, '0));
    // compare with no words read counts as a match
    issue(mk(KindCmd, CmdCompare, 3'd6, 32'h7FFF_F000, 1'b0, '0, '0));
    issue(mk(KindDone, 8'd0, 3'd0, '0, 1'b0, '0, '0));

    // random traffic, one slot count per phase; jobs may stay queued across
    counted = 0;
    for (int ph = 0; counted < RandomItems; ph++) begin
      limit_v = (ph < 7) ? 4'(slot_plan[ph]) : 4'($urandom_range(0, 8));
      drain_and_configure(limit_v);
      idle_on = ($urandom_range(0, 3) != 0);
      quota_end = counted + ((limit_v == 0) ? 40 : 220);
      while (counted < quota_end) begin
        issue(random_request());
        pause_sender(gap_cycles(idle_on));
      end
    end

    start <= 1'b0;
    while (tracker.awaited.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (tracker.error_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hdl
hdl/fswq_pkg.sv
hdl/fswq_ram.sv
hdl/flash_sector_writeback_queue.sv
hdl/fswq_checker.sv
test/flash_sector_writeback_queue_tb.sv
